// ===== rtl/core/lkv_pkg.sv =====
// ============================================================================
// lkv_pkg: shared types and constants for the LRU key-value cache
// Transfer types of both channels, controller/datapath command and status
// bundles, operation codes and reset defaults.
// ============================================================================
package lkv_pkg;

    localparam int DEFAULT_MAX_ENTRIES = 16;
    localparam int CAP_W               = 5;
    localparam int CAP_RESET_VAL       = 16;
    localparam int DATA_W              = 32;

    // Operation codes carried in the opcode field.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef struct packed {
        logic                     opcode;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic apply;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
    } dp_stat_t;

endpackage

// ===== rtl/core/lkv_ctrl.sv =====
// ============================================================================
// lkv_ctrl: sequencing state machine of the LRU key-value cache
// Steps one request through load, entry scan, update and result strobe.
// ============================================================================
module lkv_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  lkv_pkg::dp_stat_t stat,
    output lkv_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              done
);
    import lkv_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_APPLY = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

// ===== rtl/core/lkv_dp.sv =====
// ============================================================================
// lkv_dp: datapath of the LRU key-value cache
// Key and value memories, valid bits, recency ranks, entry count and the
// single key comparator that walks all entries once per request.
// ============================================================================
module lkv_dp #(
    parameter int MaxEntries = lkv_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata,
    input  lkv_pkg::req_t            request,
    input  lkv_pkg::dp_cmd_t         cmd,
    output lkv_pkg::dp_stat_t        stat,
    output lkv_pkg::rsp_t            response
);
    import lkv_pkg::*;

    localparam int IW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
    localparam int AW = IW;
    localparam int CW = $clog2(MaxEntries + 1);
    localparam int CapResetEff = (CAP_RESET_VAL > MaxEntries) ? MaxEntries : CAP_RESET_VAL;

    // Storage
    logic signed [DATA_W-1:0] key_mem [MaxEntries];
    logic signed [DATA_W-1:0] val_mem [MaxEntries];
    logic [MaxEntries-1:0]    valid_reg, valid_next;
    logic [AW-1:0]            age_reg  [MaxEntries];
    logic [AW-1:0]            age_next [MaxEntries];
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            cap_reg, cap_next;

    // Current request and scan state
    req_t                     req_reg;
    logic [IW:0]              rd_ptr_reg, rd_ptr_next;
    logic                     cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]            cmp_idx_reg, cmp_idx_next;
    logic signed [DATA_W-1:0] key_rd_reg;
    logic                     found_reg, found_next;
    logic [IW-1:0]            found_idx_reg, found_idx_next;
    logic                     free_found_reg, free_found_next;
    logic [IW-1:0]            free_idx_reg, free_idx_next;
    logic [IW-1:0]            old_idx_reg, old_idx_next;

    // Result registers
    logic                     hit_reg, evict_reg, rd_sel_reg;
    logic signed [DATA_W-1:0] val_rd_reg;

    logic [CW-1:0]            count_m1;
    logic [CW-1:0]            cap_wr_eff;
    logic                     evict;
    logic [IW-1:0]            slot_idx;
    logic [AW-1:0]            touch_age;
    logic                     rd_issue;

    assign count_m1  = count_reg - CW'(1);
    assign evict     = (count_reg >= cap_reg);
    assign touch_age = age_reg[found_idx_reg];
    assign rd_issue  = cmd.scan && (rd_ptr_reg < (IW+1)'(MaxEntries));

    // A zero capacity acts as one; anything above the store size saturates.
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cap_wr_eff = CW'(1);
        end
        else if (32'(cfg_wdata) > 32'(MaxEntries))
        begin
            cap_wr_eff = CW'(MaxEntries);
        end
        else
        begin
            cap_wr_eff = CW'(cfg_wdata);
        end
    end

    // The freed victim slot competes with the first free slot; lower wins.
    always_comb
    begin
        if (!evict)
        begin
            slot_idx = free_idx_reg;
        end
        else if (!free_found_reg || (old_idx_reg < free_idx_reg))
        begin
            slot_idx = old_idx_reg;
        end
        else
        begin
            slot_idx = free_idx_reg;
        end
    end

    // Walk: address issue in a cycle, compare of the read data in the next.
    always_comb
    begin
        rd_ptr_next     = rd_ptr_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        old_idx_next    = old_idx_reg;
        if (cmd.load)
        begin
            rd_ptr_next     = '0;
            found_next      = 1'b0;
            free_found_next = 1'b0;
        end
        else
        begin
            if (rd_issue)
            begin
                rd_ptr_next  = rd_ptr_reg + (IW+1)'(1);
                cmp_vld_next = 1'b1;
                cmp_idx_next = rd_ptr_reg[IW-1:0];
            end
            if (cmp_vld_reg)
            begin
                if (valid_reg[cmp_idx_reg])
                begin
                    if (!found_reg && (key_rd_reg == req_reg.key))
                    begin
                        found_next     = 1'b1;
                        found_idx_next = cmp_idx_reg;
                    end
                    if (CW'(age_reg[cmp_idx_reg]) == count_m1)
                    begin
                        old_idx_next = cmp_idx_reg;
                    end
                end
                else if (!free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
            end
        end
    end

    assign stat.scan_done = cmp_vld_reg && (cmp_idx_reg == IW'(MaxEntries - 1));

    // Valid bits, recency ranks and fill count.
    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        count_next = count_reg;
        cap_next   = cap_reg;
        if (cfg_we)
        begin
            cap_next   = cap_wr_eff;
            valid_next = '0;
            count_next = '0;
            for (int i = 0; i < MaxEntries; i++)
            begin
                age_next[i] = '0;
            end
        end
        else if (cmd.apply)
        begin
            if (found_reg)
            begin
                for (int i = 0; i < MaxEntries; i++)
                begin
                    if (valid_reg[i] && (age_reg[i] < touch_age))
                    begin
                        age_next[i] = age_reg[i] + AW'(1);
                    end
                end
                age_next[found_idx_reg] = '0;
            end
            else if (req_reg.opcode == OP_SET)
            begin
                if (evict)
                begin
                    valid_next[old_idx_reg] = 1'b0;
                    age_next[old_idx_reg]   = '0;
                end
                for (int i = 0; i < MaxEntries; i++)
                begin
                    if (valid_next[i])
                    begin
                        age_next[i] = age_reg[i] + AW'(1);
                    end
                end
                valid_next[slot_idx] = 1'b1;
                age_next[slot_idx]   = '0;
                if (!evict)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            count_reg      <= '0;
            cap_reg        <= CW'(CapResetEff);
            rd_ptr_reg     <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            found_reg      <= 1'b0;
            found_idx_reg  <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            old_idx_reg    <= '0;
            for (int i = 0; i < MaxEntries; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            cap_reg        <= cap_next;
            rd_ptr_reg     <= rd_ptr_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            found_reg      <= found_next;
            found_idx_reg  <= found_idx_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            old_idx_reg    <= old_idx_next;
            age_reg        <= age_next;
        end
    end

    // Request capture and result flags.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.apply)
        begin
            hit_reg    <= found_reg;
            rd_sel_reg <= found_reg && (req_reg.opcode == OP_GET);
            evict_reg  <= !found_reg && (req_reg.opcode == OP_SET) && evict;
        end
    end

    // Key memory: read by the walk, written on insertion.
    always_ff @(posedge clk)
    begin
        if (cmd.apply && !found_reg && (req_reg.opcode == OP_SET))
        begin
            key_mem[slot_idx] <= req_reg.key;
        end
        else if (rd_issue)
        begin
            key_rd_reg <= key_mem[rd_ptr_reg[IW-1:0]];
        end
    end

    // Value memory: read on a get hit, written on update or insertion.
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            if (found_reg)
            begin
                if (req_reg.opcode == OP_SET)
                begin
                    val_mem[found_idx_reg] <= req_reg.value;
                end
                else
                begin
                    val_rd_reg <= val_mem[found_idx_reg];
                end
            end
            else if (req_reg.opcode == OP_SET)
            begin
                val_mem[slot_idx] <= req_reg.value;
            end
        end
    end

    assign response.hit        = hit_reg;
    assign response.read_value = rd_sel_reg ? val_rd_reg : '0;
    assign response.evicted    = evict_reg;

endmodule

// ===== rtl/core/lru_key_value_cache_top.sv =====
// ============================================================================
// lru_key_value_cache_top: fully associative key-value cache, LRU replacement
// Top level joining the sequencing controller and the storage datapath.
// ============================================================================
// Usage:
// A request (get or set, key, value) is transferred at a rising edge where
// start is high and busy is low. Busy stays high until the result has been
// shown, so one request is in flight at a time.
// The result (hit, read_value, evicted) is marked valid on response by done,
// which is high for exactly one cycle. The receiver cannot hold it off; it must take
// it in that cycle. read_value is zero except on a get that hits.
// Sequence: a load step, a walk in which a single key comparator visits
// every entry (the key memory read is registered, so each compare trails
// its address issue), an update step and a result step. A new request can
// be taken the cycle after done, so requests never overlap.
// Configuration: cfg_we with cfg_wdata writes the capacity, clamped to the
// range 1 to MaxEntries, and empties the store. It is to be written only
// while idle; the user is bound to this, the block does not enforce it.
// Reset empties the store and sets the capacity to 16 (or MaxEntries if less).
// There is no memory clearing pass: valid bits mark live entries.
module lru_key_value_cache_top #(
    parameter int MaxEntries = lkv_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  lkv_pkg::req_t             request,
    output logic                      busy,
    output logic                      done,
    output lkv_pkg::rsp_t             response,
    input  logic                      cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata
);
    import lkv_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller only sequences; all storage lives in the datapath.
    lkv_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    lkv_dp #(
        .MaxEntries (MaxEntries)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (request),
        .cmd       (cmd),
        .stat      (stat),
        .response  (response)
    );

    // An accepted request keeps the block busy in the following cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request transfer");

    // Each result is strobed for a single cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // Eviction only happens on a miss.
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (done && response.evicted) |-> !response.hit)
        else $error("eviction reported on a hit");

    // A nonzero read value only comes from a hit.
    a_value_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (response.read_value != '0)) |-> response.hit)
        else $error("read value returned without a hit");

endmodule

// ===== test/tb.sv =====
// ============================================================================
// tb: self-checking testbench for lru_key_value_cache_top
// Drives get and set requests through the command port and rewrites the
// capacity between phases. An in-bench LRU model predicts hit, read_value and
// evicted for every request, and each result strobe is compared field by
// field with the oldest prediction.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lkv_pkg::*;

    localparam int Entries     = DEFAULT_MAX_ENTRIES;
    // Time from a transfer to its result strobe, derived from the entry count.
    localparam int DoneLatency = Entries + 2;
    localparam int StallLimit  = 2000;
    localparam int PhaseItems  = 130;

    logic             clk;
    logic             rst_n;
    logic             start;
    req_t             request;
    logic             busy;
    logic             done;
    rsp_t             response;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    // Shadow copy of the cache contents. Rank 0 is the most recently used
    // entry, and the largest rank among live entries is the eviction victim.
    logic [DATA_W-1:0] shadow_key   [Entries];
    logic [DATA_W-1:0] shadow_value [Entries];
    bit                shadow_live  [Entries];
    int unsigned       shadow_rank  [Entries];
    int unsigned       shadow_count;
    int unsigned       shadow_limit;

    // Predicted responses, oldest first.
    rsp_t              pending_rsp_q[$];
    int                fail_count   = 0;
    int                stall_cycles = 0;
    // While positive, requests go out back to back with no idle gap.
    int                burst_left   = 0;
    logic [DATA_W-1:0] key_pool[$];

    lru_key_value_cache_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .response  (response),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic req_t make_req(input logic op, input logic [DATA_W-1:0] k,
                                      input logic [DATA_W-1:0] v);
        req_t r;
        r.opcode = op;
        r.key    = k;
        r.value  = v;
        return r;
    endfunction

    // Empties the shadow store and applies the capacity clamp: zero acts as
    // one, and anything above the number of entries saturates.
    task automatic clear_shadow(input int unsigned cap_raw);
        for (int i = 0; i < Entries; i++)
        begin
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_live[i]  = 1'b0;
            shadow_rank[i]  = 0;
        end
        shadow_count = 0;
        if (cap_raw == 0)
            shadow_limit = 1;
        else if (cap_raw > Entries)
            shadow_limit = Entries;
        else
            shadow_limit = cap_raw;
    endtask

    // Works out the response to one request and updates the shadow store.
    task automatic predict_lru_access(input req_t req, output rsp_t rsp);
        int          found;
        int          victim;
        int          free_slot;
        int unsigned old_rank;
        rsp = '0;
        found = -1;
        for (int i = 0; i < Entries; i++)
            if (found < 0 && shadow_live[i] && shadow_key[i] == req.key)
                found = i;

        if (found >= 0)
        begin
            rsp.hit = 1'b1;
            if (req.opcode == OP_GET)
                rsp.read_value = shadow_value[found];
            else
                shadow_value[found] = req.value;
            // Promote to newest: everything that was newer ages by one.
            old_rank = shadow_rank[found];
            for (int i = 0; i < Entries; i++)
                if (shadow_live[i] && shadow_rank[i] < old_rank)
                    shadow_rank[i]++;
            shadow_rank[found] = 0;
        end
        else if (req.opcode == OP_SET)
        begin
            if (shadow_count >= shadow_limit)
            begin
                // The first live entry holding the largest rank is dropped.
                victim = -1;
                for (int i = 0; i < Entries; i++)
                    if (shadow_live[i] &&
                        (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
                        victim = i;
                if (victim >= 0)
                begin
                    shadow_live[victim] = 1'b0;
                    shadow_rank[victim] = 0;
                    if (shadow_count > 0)
                        shadow_count--;
                    rsp.evicted = 1'b1;
                end
            end
            free_slot = -1;
            for (int i = 0; i < Entries; i++)
                if (free_slot < 0 && !shadow_live[i])
                    free_slot = i;
            if (free_slot >= 0)
            begin
                for (int i = 0; i < Entries; i++)
                    if (shadow_live[i])
                        shadow_rank[i]++;
                shadow_key[free_slot]   = req.key;
                shadow_value[free_slot] = req.value;
                shadow_live[free_slot]  = 1'b1;
                shadow_rank[free_slot]  = 0;
                shadow_count++;
            end
        end
    endtask

    // Sends one request. A random gap of zero keeps start high so the
    // request is taken the cycle after the previous result; otherwise start
    // drops, the bench waits for the block to go idle and then idles for the
    // drawn number of cycles, so gaps land at different points after done.
    task automatic send_request(input req_t req);
        int   gap;
        rsp_t want;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(8, 30);
        end

        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        request <= req;

        // The transfer happens at the first rising edge that sees busy low.
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_lru_access(req, want);
        pending_rsp_q.insert(pending_rsp_q.size(), want);
    endtask

    // Drops start, waits for every predicted result and then lets the
    // block's latency pass so that it is surely idle.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DoneLatency) @(posedge clk);
    endtask

    // Capacity writes happen only with the block idle. The write also
    // empties the store, so the shadow copy is cleared with it.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we    <= 1'b0;
        clear_shadow(cap);
    endtask

    // Default capacity after reset: misses on an empty store, extreme keys
    // and values, set hits that overwrite, and a get that carries a value
    // which must be ignored.
    task automatic test_basic_access();
        send_request(make_req(OP_GET, 32'h0000_0000, 32'h0000_0000));
        send_request(make_req(OP_SET, 32'h8000_0000, 32'h7fff_ffff));
        send_request(make_req(OP_SET, 32'h7fff_ffff, 32'h8000_0000));
        send_request(make_req(OP_SET, 32'hffff_ffff, 32'hffff_ffff));
        send_request(make_req(OP_GET, 32'h8000_0000, 32'h0000_0000));
        send_request(make_req(OP_GET, 32'hffff_ffff, 32'hffff_ffff));
        send_request(make_req(OP_SET, 32'h8000_0000, 32'h0000_0000));
        send_request(make_req(OP_GET, 32'h8000_0000, 32'hffff_ffff));
        send_request(make_req(OP_GET, 32'h0000_0000, 32'h0000_0000));
        send_request(make_req(OP_GET, 32'h7fff_ffff, 32'h1234_5678));
    endtask

    // A capacity of zero must act as one: each new key evicts the last.
    task automatic test_capacity_zero();
        write_capacity(5'd0);
        send_request(make_req(OP_SET, 32'h0000_0001, 32'hdead_beef));
        send_request(make_req(OP_SET, 32'h0000_0002, 32'h0bad_f00d));
        send_request(make_req(OP_GET, 32'h0000_0001, 32'h0000_0000));
        send_request(make_req(OP_GET, 32'h0000_0002, 32'h0000_0000));
    endtask

    // With two entries, a get hit must save its entry from the next
    // eviction, which then falls on the other one.
    task automatic test_lru_order();
        write_capacity(5'd2);
        send_request(make_req(OP_SET, 32'h0000_000a, 32'h0000_0064));
        send_request(make_req(OP_SET, 32'h0000_0014, 32'h0000_00c8));
        send_request(make_req(OP_GET, 32'h0000_000a, 32'h0000_0000));
        send_request(make_req(OP_SET, 32'h0000_001e, 32'h0000_012c));
        send_request(make_req(OP_GET, 32'h0000_0014, 32'h0000_0000));
        send_request(make_req(OP_GET, 32'h0000_000a, 32'h0000_0000));
        send_request(make_req(OP_SET, 32'h0000_000a, 32'hffff_fffe));
    endtask

    // Random phases, each with its own capacity. Keys come mostly from a
    // pool a little larger than the capacity, so hits, updates and
    // evictions all happen often; one key in ten is fully random noise.
    task automatic test_random_phases();
        logic [CAP_W-1:0]  caps[10];
        int                pool_size;
        logic [DATA_W-1:0] k;
        logic [DATA_W-1:0] v;
        logic              op;
        caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd8, 5'd0, 5'd0, 5'd16, 5'd4};
        caps[6] = CAP_W'($urandom_range(3, 15));
        caps[7] = CAP_W'($urandom_range(0, 31));

        foreach (caps[p])
        begin
            write_capacity(caps[p]);
            key_pool.delete();
            pool_size = shadow_limit + $urandom_range(0, 3);
            for (int i = 0; i < pool_size; i++)
            begin
                case ($urandom_range(0, 15))
                    0:       key_pool.insert(key_pool.size(), 32'h8000_0000);
                    1:       key_pool.insert(key_pool.size(), 32'h7fff_ffff);
                    2:       key_pool.insert(key_pool.size(), 32'h0000_0000);
                    3:       key_pool.insert(key_pool.size(), 32'hffff_ffff);
                    default: key_pool.insert(key_pool.size(), $urandom);
                endcase
            end

            for (int n = 0; n < PhaseItems; n++)
            begin
                op = $urandom_range(0, 1) ? OP_SET : OP_GET;
                if ($urandom_range(0, 9) == 0)
                    k = $urandom;
                else
                    k = key_pool[$urandom_range(0, pool_size - 1)];
                case ($urandom_range(0, 15))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = 32'h0000_0000;
                    default: v = $urandom;
                endcase
                send_request(make_req(op, k, v));
            end
        end
    endtask

    // Every result strobe is matched against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $error("result strobe with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_rsp_q[0];
                pending_rsp_q.delete(0);
                if (response.hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, response.hit);
                    fail_count++;
                end
                if (response.read_value !== want.read_value)
                begin
                    $error("read_value: expected %08h, got %08h",
                           want.read_value, response.read_value);
                    fail_count++;
                end
                if (response.evicted !== want.evicted)
                begin
                    $error("evicted: expected %0d, got %0d",
                           want.evicted, response.evicted);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: any cycle with a request transfer or a result restarts the
    // count. A hang in either direction ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= StallLimit)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        // All inputs are known from time zero; reset is asserted from time zero
        // and released on a falling edge.
        rst_n     = 1'b0;
        start     = 1'b0;
        request   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        clear_shadow(CAP_RESET_VAL);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_access();
        test_capacity_zero();
        test_lru_order();
        test_random_phases();

        drain_results();
        if (pending_rsp_q.size() != 0)
        begin
            $error("%0d predicted results never arrived", pending_rsp_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
